/* sv/sha256_hash_engine_defines.svh */
// Assertion macros for the SHA-256 engine
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");
`define SHA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/sha_pkg.sv */
`default_nettype none
package sha_pkg;
   localparam int unsigned WordW = 32;
   localparam int unsigned CountW = 61;

   typedef logic [WordW-1:0] word_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ROUND = 7'b0000010,
      ST_ADD   = 7'b0000100,
      ST_PADB  = 7'b0001000,
      ST_LEN   = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_CLR   = 7'b1000000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_byte;   // write input byte into block buffer
      logic       pad_write;   // write pad / zero / length byte
      logic [5:0] pad_addr;
      logic [7:0] pad_data;
      logic       init_vars;   // working vars <- hash words
      logic       round;       // run one round
      logic [5:0] round_idx;
      logic       add_hash;    // hash words += working vars
      logic       reset_hash;  // hash words <- initial values
      logic       count_clear;
      logic [2:0] out_idx;
   } cmd_type;

   typedef struct packed {
      logic [CountW-1:0] byte_count;
   } stat_type;

   function automatic word_type round_k(input logic [5:0] i);
      word_type k [64] = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   function automatic word_type init_hash(input logic [2:0] i);
      word_type h [8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
      return h[i];
   endfunction
endpackage
`default_nettype wire

/* sv/sha_stream_if.sv */
`default_nettype none
interface sha_stream_if #(parameter int unsigned PayloadW = 10);
   logic                valid;
   logic                ready;
   logic [PayloadW-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/sha_ctrl.sv */
`default_nettype none
module sha_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic              byte_present,
   input  wire logic              message_end,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output sha_pkg::cmd_type       cmd,
   input  wire sha_pkg::stat_type stat
);
   import sha_pkg::*;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       fin_ff, fin_in;     // compression is part of padding
   logic       two_ff, two_in;     // padding needs a second block
   logic [5:0] rem;
   logic       acc;

   // length block has been compressed once padding ran
   logic        fin_len_done;
   logic        lenw_ff, lenw_in;
   logic [63:0] bits;
   logic [7:0]  lenbyte;

   assign rem = stat.byte_count[5:0];
   assign in_ready = (state_ff == ST_IDLE);
   assign acc = in_valid && in_ready;
   assign out_valid = (state_ff == ST_EMIT);

   assign fin_len_done = lenw_ff;
   assign bits = {stat.byte_count, 3'b000};
   assign lenbyte = bits[{~cnt_ff[2:0], 3'b000} +: 8];

   // sequence the message, padding, rounds and digest output
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      fin_in = fin_ff;
      two_in = two_ff;
      lenw_in = lenw_ff;
      cmd = '0;
      cmd.round_idx = cnt_ff;
      cmd.out_idx = cnt_ff[2:0];
      cmd.pad_addr = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd.load_byte = byte_present;
               if (byte_present && rem == 6'd63) begin
                  state_in = ST_ROUND;
                  cmd.init_vars = 1'b1;
                  fin_in = message_end;
                  two_in = 1'b0;
                  cnt_in = '0;
               end else if (message_end) begin
                  state_in = ST_PADB;
                  cnt_in = byte_present ? rem + 6'd1 : rem;
                  two_in = 1'b0;
               end
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_hash = 1'b1;
            cnt_in = '0;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (two_ff) begin
               // first pad block done: zero 0..55 then length
               state_in = ST_CLR;
               two_in = 1'b0;
            end else if (stat.byte_count[5:0] == 6'd0 && !fin_len_done) begin
               state_in = ST_PADB;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_PADB: begin
            // 0x80 at the first free byte, then zeros
            cmd.pad_write = 1'b1;
            cmd.pad_data = (cnt_ff == rem) ? 8'h80 : 8'h00;
            fin_in = 1'b1;
            if (cnt_ff == 6'd63) begin
               if (rem >= 6'd56) begin
                  two_in = 1'b1;
                  state_in = ST_ROUND;
                  cmd.init_vars = 1'b1;
                  cnt_in = '0;
               end else begin
                  state_in = ST_LEN;
                  cnt_in = 6'd56;
               end
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_CLR: begin
            cmd.pad_write = 1'b1;
            cmd.pad_data = 8'h00;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) state_in = ST_LEN;
         end
         ST_LEN: begin
            cmd.pad_write = 1'b1;
            cmd.pad_data = lenbyte;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_ROUND;
               cmd.init_vars = 1'b1;
               two_in = 1'b0;
               fin_in = 1'b1;
               cnt_in = '0;
               lenw_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  state_in = ST_IDLE;
                  cmd.reset_hash = 1'b1;
                  cmd.count_clear = 1'b1;
                  cnt_in = '0;
                  fin_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_ADD && state_in != ST_PADB) lenw_in = 1'b0;
      if (state_ff == ST_IDLE) lenw_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         fin_ff <= 1'b0;
         two_ff <= 1'b0;
         lenw_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         fin_ff <= fin_in;
         two_ff <= two_in;
         lenw_ff <= lenw_in;
      end
   end
endmodule
`default_nettype wire

/* sv/sha_datapath.sv */
`default_nettype none
module sha_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sha_pkg::cmd_type cmd,
   input  wire logic [7:0]       data_byte,
   output sha_pkg::stat_type     stat,
   output logic [31:0]           digest_word
);
   import sha_pkg::*;

   word_type          h_ff [8];
   word_type          v_ff [8];
   word_type          w_ff [16];
   logic [CountW-1:0] cnt_ff;
   word_type          w, s1, ch, t1, s0, mj, g0, g1;
   logic [3:0]        ri;
   logic              wr_en;
   logic [5:0]        wr_addr;
   logic [7:0]        wr_byte;

   assign stat.byte_count = cnt_ff;
   assign digest_word = h_ff[cmd.out_idx];
   assign ri = cmd.round_idx[3:0];

   // message and pad bytes land big-endian in the schedule window
   assign wr_en = cmd.load_byte || cmd.pad_write;
   assign wr_addr = cmd.load_byte ? cnt_ff[5:0] : cmd.pad_addr;
   assign wr_byte = cmd.load_byte ? data_byte : cmd.pad_data;

   // one round: schedule word and compression step
   always_comb begin
      g0 = {w_ff[ri+4'd1][6:0], w_ff[ri+4'd1][31:7]} ^ {w_ff[ri+4'd1][17:0],
           w_ff[ri+4'd1][31:18]} ^ (w_ff[ri+4'd1] >> 3);
      g1 = {w_ff[ri+4'd14][16:0], w_ff[ri+4'd14][31:17]} ^ {w_ff[ri+4'd14][18:0],
           w_ff[ri+4'd14][31:19]} ^ (w_ff[ri+4'd14] >> 10);
      w = (cmd.round_idx < 6'd16) ? w_ff[ri] : w_ff[ri] + g0 + w_ff[ri+4'd9] + g1;
      s1 = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]} ^
           {v_ff[4][24:0], v_ff[4][31:25]};
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + round_k(cmd.round_idx) + w;
      s0 = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]} ^
           {v_ff[0][21:0], v_ff[0][31:22]};
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         w_ff[ri] <= w;
      end else if (wr_en) begin
         w_ff[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
      end
      if (cmd.init_vars) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (cmd.round) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + s0 + mj;
      end
   end

   // hash words and byte counter
   always_ff @(posedge clock) begin
      if (reset || cmd.reset_hash) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else if (cmd.add_hash) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
      if (reset || cmd.count_clear) cnt_ff <= '0;
      else if (cmd.load_byte) cnt_ff <= cnt_ff + 1'b1;
   end
endmodule
`default_nettype wire

/* sv/sha256_hash_engine.sv */
//  channel | dir | payload
//  req     | in  | data_byte, byte_present, message_end
//  rsp     | out | digest_word, word_index, last_word
// Idle takes one byte a cycle; the 64th byte of a block starts 64 rounds, one per cycle,
// then the hash add, with input held meanwhile.
// Message end fills the pad from the first free byte to byte 63, writes 8 length bytes
// and compresses; a tail of 56 or more bytes first compresses the pad block and zero-fills bytes 0..55.
// Eight digest transactions then wait on rsp ready, input held off until the last.
// Reset is synchronous.
`default_nettype none
`include "sha256_hash_engine_defines.svh"
module sha256_hash_engine (
   input wire logic   clock,
   input wire logic   reset,
   sha_stream_if.sink   req,
   sha_stream_if.source rsp
);
   import sha_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   logic [31:0] dw;

   sha_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .byte_present(req.payload[1]), .message_end(req.payload[0]),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .cmd, .stat
   );

   sha_datapath u_dp (
      .clock, .reset, .cmd, .data_byte(req.payload[9:2]), .stat, .digest_word(dw)
   );

   assign rsp.payload = {dw, cmd.out_idx, cmd.out_idx == 3'd7};

   `SHA_ASSERT_IMP(a_no_overlap, clock, reset, rsp.valid, !req.ready)
   `SHA_ASSERT_NXT(a_last_ends, clock, reset, rsp.valid && rsp.ready && rsp.payload[0], !rsp.valid)
endmodule
`default_nettype wire
